/* rtl/cobs_crc8_pkg.sv */
package cobs_crc8_pkg;

  localparam int unsigned MaxCommands = 16;
  localparam int unsigned CmdIdxW     = 4;
  localparam int unsigned CountW      = 5;
  localparam int unsigned PosW        = 9;
  localparam int unsigned ChainW      = 10;

  localparam logic [7:0]  CrcPoly  = 8'h4D;
  localparam logic [7:0]  TailLen  = 8'd5;

  localparam logic [63:0] TableLowReset  = 64'd30582;
  localparam logic [63:0] TableHighReset = 64'd0;
  localparam logic [4:0]  CountReset     = 5'd2;

  typedef enum logic [1:0] {
    CfgTableLow  = 2'd0,
    CfgTableHigh = 2'd1,
    CfgCount     = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StUnknownCmd = 3'd1,
    StCrcErr     = 3'd2,
    StLenErr     = 3'd3,
    StZeroByte   = 3'd4
  } status_e;

  typedef enum logic {
    KindPayload = 1'b0,
    KindEnd     = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload;
    status_e     status;
    logic [7:0]  command;
    logic [7:0]  subcommand;
    logic [7:0]  length;
    logic [3:0]  cmd_idx;
  } result_t;

  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

/* rtl/cobs_crc8_frame_receiver.sv */
// Receiver for zero-delimited, byte-stuffed command frames with a CRC-8 check.
// rx channel: one raw byte per transfer on rx_byte_i (rx_valid_i / rx_ready_o).
// out channel: one result per transfer; result_kind_o low carries an unstuffed
//   payload byte, high closes the frame with status_o and the header fields.
//   Header bytes and the CRC byte produce no result.
// cfg channel: cfg_index_i 0 and 1 write the low and high halves of the command
//   table, 2 writes the number of valid entries; always ready, write only
//   while the receiver is idle.
// A byte is registered in the input register at its transfer; its result is
//   registered in the result register, which drives out_valid_o.
// Throughput: one byte per cycle while results are taken; unstuffing, CRC
//   update, command lookup and checks run combinationally between registers.
// A full result register that is not taken holds the byte in the input
//   register; rx_ready_o stays high while the input register can move on.
// Reset clears the frame state, loads the default command table and empties
//   both registers; the first byte after reset or after any status result is
//   taken as the stuff pointer of a new frame unless it is a zero byte.
module cobs_crc8_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [2:0]  status_o,
  output logic [7:0]  command_byte_o,
  output logic [7:0]  subcommand_byte_o,
  output logic [7:0]  data_length_o,
  output logic [3:0]  command_index_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import cobs_crc8_pkg::*;

  logic [63:0]         tab_lo_q, tab_hi_q;
  logic [CountW-1:0]   count_q;

  logic                in_valid_q;
  logic [7:0]          in_byte_q;

  logic [PosW-1:0]     pos_q, pos_d;
  logic [ChainW-1:0]   chain_q, chain_d;
  logic [7:0]          crc_q, crc_d;
  logic [7:0]          cmd_q, cmd_d;
  logic [7:0]          sub_q, sub_d;
  logic [7:0]          len_q, len_d;
  logic [CmdIdxW-1:0]  match_q, match_d;
  logic                crc_ok_q, crc_ok_d;

  logic                out_valid_q, out_valid_d;
  result_t             res_q, res_d;

  logic                fire;
  logic                emit;
  logic [PosW-1:0]     end_pos;
  logic                hit;
  logic [7:0]          ubyte;
  logic [ChainW-1:0]   chain_adv;
  logic [127:0]        table_all;
  logic [CountW-1:0]   n_cmds;
  logic                lk_found;
  logic [CmdIdxW-1:0]  lk_idx;

  assign cfg_ready_o = 1'b1;
  assign fire        = in_valid_q && (!out_valid_q || out_ready_i);
  assign rx_ready_o  = !in_valid_q || fire;

  // Command lookup: first match wins among the valid entries.
  assign table_all = {tab_hi_q, tab_lo_q};
  assign n_cmds    = (count_q > CountW'(MaxCommands)) ? CountW'(MaxCommands) : count_q;

  always_comb begin
    lk_found = 1'b0;
    lk_idx   = '0;
    for (int i = MaxCommands - 1; i >= 0; i--) begin
      if ((CountW'(i) < n_cmds) && (table_all[i*8 +: 8] == cmd_q)) begin
        lk_found = 1'b1;
        lk_idx   = CmdIdxW'(i);
      end
    end
  end

  assign end_pos   = {1'b0, len_q} + PosW'(TailLen);
  assign hit       = ({1'b0, pos_q} == chain_q);
  assign ubyte     = hit ? 8'h00 : in_byte_q;
  assign chain_adv = hit ? (chain_q + ChainW'(in_byte_q)) : chain_q;

  always_comb begin
    logic          close;
    status_e       st;
    logic [7:0]    len_new;
    logic [PosW-1:0] end_new;

    close    = 1'b0;
    st       = StOk;
    len_new  = ubyte;
    end_new  = {1'b0, len_new} + PosW'(TailLen);
    emit     = 1'b0;

    pos_d    = pos_q;
    chain_d  = chain_q;
    crc_d    = crc_q;
    cmd_d    = cmd_q;
    sub_d    = sub_q;
    len_d    = len_q;
    match_d  = match_q;
    crc_ok_d = crc_ok_q;

    res_d         = res_q;
    res_d.kind    = KindPayload;
    res_d.payload = 8'h00;
    res_d.status  = StOk;

    if (pos_q >= PosW'(4) && pos_q == end_pos) begin
      close = 1'b1;
      st    = (in_byte_q != 8'h00) ? StLenErr : (crc_ok_q ? StOk : StCrcErr);
    end else if (in_byte_q == 8'h00) begin
      close = 1'b1;
      st    = StZeroByte;
    end else begin
      chain_d = chain_adv;
      if (pos_q == '0) begin
        pos_d = PosW'(1);
      end else if (pos_q < PosW'(4)) begin
        crc_d = crc8_update(crc_q, ubyte);
        pos_d = pos_q + PosW'(1);
        if (pos_q == PosW'(1)) begin
          cmd_d = ubyte;
        end else if (pos_q == PosW'(2)) begin
          sub_d = ubyte;
        end else begin
          len_d = len_new;
          if (!lk_found) begin
            close = 1'b1;
            st    = StUnknownCmd;
          end else begin
            match_d = lk_idx;
            if ({1'b0, end_new} < chain_adv) begin
              close = 1'b1;
              st    = StLenErr;
            end
          end
        end
      end else if (pos_q < end_pos - PosW'(1)) begin
        crc_d         = crc8_update(crc_q, ubyte);
        pos_d         = pos_q + PosW'(1);
        emit          = 1'b1;
        res_d.payload = ubyte;
      end else begin
        crc_ok_d = (ubyte == crc_q);
        pos_d    = pos_q + PosW'(1);
      end
    end

    res_d.command    = cmd_d;
    res_d.subcommand = sub_d;
    res_d.length     = len_d;
    res_d.cmd_idx    = match_d;

    if (close) begin
      emit          = 1'b1;
      res_d.kind    = KindEnd;
      res_d.payload = 8'h00;
      res_d.status  = st;
      res_d.cmd_idx = (st == StOk) ? match_d : '0;
      pos_d    = '0;
      chain_d  = '0;
      crc_d    = '0;
      cmd_d    = '0;
      sub_d    = '0;
      len_d    = '0;
      match_d  = '0;
      crc_ok_d = 1'b0;
    end
  end

  always_comb begin
    if (fire) begin
      out_valid_d = emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_lo_q <= TableLowReset;
      tab_hi_q <= TableHighReset;
      count_q  <= CountReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgTableLow:  tab_lo_q <= cfg_data_i;
        CfgTableHigh: tab_hi_q <= cfg_data_i;
        CfgCount:     count_q  <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_ready_o) begin
      in_valid_q <= rx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_ready_o && rx_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      chain_q  <= '0;
      crc_q    <= '0;
      cmd_q    <= '0;
      sub_q    <= '0;
      len_q    <= '0;
      match_q  <= '0;
      crc_ok_q <= 1'b0;
    end else if (fire) begin
      pos_q    <= pos_d;
      chain_q  <= chain_d;
      crc_q    <= crc_d;
      cmd_q    <= cmd_d;
      sub_q    <= sub_d;
      len_q    <= len_d;
      match_q  <= match_d;
      crc_ok_q <= crc_ok_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_kind_o     = res_q.kind;
  assign payload_byte_o    = res_q.payload;
  assign status_o          = res_q.status;
  assign command_byte_o    = res_q.command;
  assign subcommand_byte_o = res_q.subcommand;
  assign data_length_o     = res_q.length;
  assign command_index_o   = res_q.cmd_idx;

  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= end_pos)
    else $error("frame position past terminator");

  a_payload_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.kind == KindPayload |-> res_q.status == StOk)
    else $error("payload result carries an error status");

  a_err_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.kind == KindEnd && res_q.status != StOk
      |-> res_q.cmd_idx == '0 && res_q.payload == 8'h00)
    else $error("failed frame reports command index or payload");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import cobs_crc8_pkg::*;

  localparam int DrainCycles = 4;
  localparam int CycleLimit  = 400000;

  typedef enum int {
    FlawNone,
    FlawCrc,
    FlawTerm,
    FlawZero,
    FlawChain,
    FlawByte,
    FlawCut
  } flaw_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        rx_valid_i;
  logic        rx_ready_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        result_kind_o;
  logic [7:0]  payload_byte_o;
  logic [2:0]  status_o;
  logic [7:0]  command_byte_o;
  logic [7:0]  subcommand_byte_o;
  logic [7:0]  data_length_o;
  logic [3:0]  command_index_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  cobs_crc8_frame_receiver u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rx_valid_i       (rx_valid_i),
    .rx_ready_o       (rx_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_kind_o    (result_kind_o),
    .payload_byte_o   (payload_byte_o),
    .status_o         (status_o),
    .command_byte_o   (command_byte_o),
    .subcommand_byte_o(subcommand_byte_o),
    .data_length_o    (data_length_o),
    .command_index_o  (command_index_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // Decoder state mirrored by the predictor
  int          frame_pos;
  logic [9:0]  zero_chain;
  logic [7:0]  crc_acc;
  logic [7:0]  hdr_cmd;
  logic [7:0]  hdr_sub;
  logic [7:0]  hdr_len;
  logic [3:0]  hit_idx;
  bit          crc_ok;
  logic [63:0] tbl_lo;
  logic [63:0] tbl_hi;
  logic [4:0]  cmd_count;

  result_t     awaited_results[$];
  logic [7:0]  frame_bytes[$];
  int          bytes_sent;
  int          fails;
  int unsigned cycle_count = 0;
  bit          src_idle;
  bit          sink_idle;
  int          hold_request;
  int          hold_left;

  always #1 clk_i = ~clk_i;

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    repeat (8) c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    return c;
  endfunction

  function automatic int eff_count();
    return (cmd_count > MaxCommands) ? MaxCommands : int'(cmd_count);
  endfunction

  function automatic logic [7:0] table_char(input int i);
    logic [127:0] t;
    t = {tbl_hi, tbl_lo};
    return t[i*8 +: 8];
  endfunction

  function automatic void push_expected(input kind_e k, input logic [7:0] pay,
                                        input status_e st);
    result_t r;
    r.kind       = k;
    r.payload    = pay;
    r.status     = st;
    r.command    = hdr_cmd;
    r.subcommand = hdr_sub;
    r.length     = hdr_len;
    r.cmd_idx    = (st == StOk) ? hit_idx : 4'd0;
    awaited_results.push_back(r);
  endfunction

  function automatic void close_frame(input status_e st);
    push_expected(KindEnd, 8'h00, st);
    frame_pos  = 0;
    zero_chain = '0;
    crc_acc    = '0;
    hdr_cmd    = '0;
    hdr_sub    = '0;
    hdr_len    = '0;
    hit_idx    = '0;
    crc_ok     = 1'b0;
  endfunction

  function automatic void decode_byte(input logic [7:0] raw);
    logic [7:0] plain;
    logic [3:0] idx;
    bit         found;
    plain = raw;
    if (frame_pos >= 4 && frame_pos == int'(hdr_len) + 5) begin
      if (raw != 8'h00) close_frame(StLenErr);
      else close_frame(crc_ok ? StOk : StCrcErr);
      return;
    end
    if (raw == 8'h00) begin
      close_frame(StZeroByte);
      return;
    end
    if (frame_pos == int'(zero_chain)) begin
      plain      = 8'h00;
      zero_chain = zero_chain + 10'(raw);
    end
    if (frame_pos == 0) begin
      frame_pos = 1;
      return;
    end
    if (frame_pos < 4) begin
      crc_acc = crc8_next(crc_acc, plain);
      case (frame_pos)
        1: hdr_cmd = plain;
        2: hdr_sub = plain;
        default: begin
          hdr_len = plain;
          found   = 1'b0;
          idx     = '0;
          for (int i = 0; i < MaxCommands; i++) begin
            if (!found && i < eff_count() && table_char(i) == hdr_cmd) begin
              found = 1'b1;
              idx   = i[3:0];
            end
          end
          if (!found) begin
            close_frame(StUnknownCmd);
            return;
          end
          hit_idx = idx;
          if (int'(hdr_len) + 5 < int'(zero_chain)) begin
            close_frame(StLenErr);
            return;
          end
        end
      endcase
      frame_pos++;
      return;
    end
    if (frame_pos < int'(hdr_len) + 4) begin
      crc_acc = crc8_next(crc_acc, plain);
      frame_pos++;
      push_expected(KindPayload, plain, StOk);
      return;
    end
    crc_ok = (plain == crc_acc);
    frame_pos++;
  endfunction

  function automatic void build_frame(input logic [7:0] cmd, input logic [7:0] sub,
                                      input int len, input flaw_e flaw);
    logic [7:0] plain[$];
    logic [7:0] b;
    logic [7:0] crc;
    int         last;
    int         nxt;
    int         cut;
    plain = {8'h00, cmd, sub, 8'(len)};
    frame_bytes.delete();
    last = 0;
    for (int i = 1; i < 4; i++) if (plain[i] == 8'h00) last = i;
    for (int i = 4; i < len + 4; i++) begin
      b = ($urandom_range(99) < 12) ? 8'h00 : 8'($urandom_range(1, 255));
      if (i - last >= 200) b = 8'h00;
      if (b == 8'h00) last = i;
      plain.push_back(b);
    end
    crc = '0;
    for (int i = 1; i < len + 4; i++) crc = crc8_next(crc, plain[i]);
    if (flaw == FlawCrc) crc ^= 8'($urandom_range(1, 255));
    plain.push_back(crc);
    plain.push_back(8'h00);
    for (int i = 0; i < len + 5; i++) begin
      if (plain[i] == 8'h00) begin
        nxt = i + 1;
        while (plain[nxt] != 8'h00) nxt++;
        frame_bytes.push_back(8'(nxt - i));
      end else begin
        frame_bytes.push_back(plain[i]);
      end
    end
    frame_bytes.push_back(8'h00);
    case (flaw)
      FlawTerm:  frame_bytes[len + 5] = 8'($urandom_range(1, 255));
      FlawZero:  frame_bytes[$urandom_range(0, len + 4)] = 8'h00;
      FlawChain: frame_bytes[0] = 8'($urandom_range(1, 255));
      FlawByte:  frame_bytes[$urandom_range(0, len + 5)] = 8'($urandom_range(0, 255));
      FlawCut: begin
        cut = $urandom_range(1, len + 5);
        while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      end
      default: ;
    endcase
  endfunction

  function automatic void make_random_frame(input int flaw_pct);
    int         len;
    int         r;
    logic [7:0] cmd;
    flaw_e      flaw;
    r   = $urandom_range(99);
    len = (r < 70) ? $urandom_range(0, 12) :
          (r < 98) ? $urandom_range(13, 60) : $urandom_range(200, 255);
    if (eff_count() > 0 && $urandom_range(99) < 85)
      cmd = table_char($urandom_range(0, eff_count() - 1));
    else
      cmd = 8'($urandom_range(0, 255));
    flaw = ($urandom_range(99) < flaw_pct) ? flaw_e'($urandom_range(1, 6)) : FlawNone;
    build_frame(cmd, 8'($urandom_range(0, 255)), len, flaw);
  endfunction

  // Called at a rising edge; returns at the edge of the transfer.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (src_idle && $urandom_range(99) < 27) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      rx_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(negedge clk_i); while (!rx_ready_o);
    @(posedge clk_i);
    decode_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
  endtask

  task automatic wait_drain(input int extra);
    rx_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] count);
    cfg_idx_e    idx;
    logic [63:0] data;
    if (frame_pos != 0) send_byte(8'h00);
    wait_drain(DrainCycles);
    for (int i = 0; i < 3; i++) begin
      idx  = cfg_idx_e'(i);
      data = (idx == CfgTableLow) ? lo : (idx == CfgTableHigh) ? hi : 64'(count);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= data;
      do @(negedge clk_i); while (!cfg_ready_o);
      @(posedge clk_i);
      case (idx)
        CfgTableLow:  tbl_lo = data;
        CfgTableHigh: tbl_hi = data;
        default:      cmd_count = data[4:0];
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_directed();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    send_byte(8'h00);
    build_frame(8'h76, 8'hFF, 0, FlawNone);
    send_frame();
    build_frame(8'h41, 8'h7F, 0, FlawNone);
    send_frame();
    build_frame(8'h77, 8'h10, 0, FlawCrc);
    send_frame();
    build_frame(8'h76, 8'h01, 0, FlawTerm);
    send_frame();
    send_byte(8'h20);
    send_byte(8'h76);
    send_byte(8'h01);
    send_byte(8'h01);
    wait_drain(0);
  endtask

  task automatic test_full_rate();
    int first;
    first     = bytes_sent;
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    while (bytes_sent - first < 150) begin
      make_random_frame(20);
      send_frame();
    end
  endtask

  task automatic test_random_frames();
    int first;
    first     = bytes_sent;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    build_frame(table_char(0), 8'hA5, 255, FlawNone);
    send_frame();
    while (bytes_sent - first < 330) begin
      make_random_frame(20);
      send_frame();
    end
  endtask

  task automatic test_command_table();
    int          first;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  count;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    for (int phase = 0; phase < 6; phase++) begin
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      case (phase)
        0: count = 5'd16;
        1: begin
          lo    = '0;
          hi    = '1;
          count = 5'd0;
        end
        2: count = 5'd31;
        3: begin
          lo    = {8{8'($urandom_range(0, 255))}};
          hi    = {8{8'($urandom_range(0, 255))}};
          count = 5'($urandom_range(1, 15));
        end
        4: begin
          lo    = '1;
          hi    = '0;
          count = 5'd16;
        end
        default: count = 5'd8;
      endcase
      write_config(lo, hi, count);
      first = bytes_sent;
      while (bytes_sent - first < 40) begin
        make_random_frame(15);
        send_frame();
      end
    end
    write_config(TableLowReset, TableHighReset, CountReset);
  endtask

  task automatic test_backpressure();
    int first;
    first        = bytes_sent;
    src_idle     = 1'b0;
    sink_idle    = 1'b1;
    hold_request = 300;
    while (bytes_sent - first < 120) begin
      make_random_frame(0);
      send_frame();
    end
    wait_drain(0);
  endtask

  task automatic test_sender_pause();
    int first;
    first     = bytes_sent;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    while (bytes_sent - first < 80) begin
      make_random_frame(20);
      foreach (frame_bytes[i]) begin
        if ($urandom_range(99) < 5) wait_drain(0);
        send_byte(frame_bytes[i]);
      end
      if ($urandom_range(99) < 40) wait_drain(0);
    end
  endtask

  task automatic test_noise();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    repeat (80) send_byte(($urandom_range(99) < 10) ? 8'h00 : 8'($urandom_range(1, 255)));
    repeat (3) begin
      make_random_frame(0);
      send_frame();
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !(sink_idle && $urandom_range(99) < 35);
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  always @(negedge clk_i) begin : check_results
    result_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        $error("result_kind: expected none, actual %0d (status %0d)",
               result_kind_o, status_o);
        fails++;
      end else begin
        want = awaited_results.pop_front();
        check_field("result_kind", 8'(want.kind), 8'(result_kind_o));
        check_field("payload_byte", want.payload, payload_byte_o);
        check_field("status", 8'(want.status), 8'(status_o));
        check_field("command_byte", want.command, command_byte_o);
        check_field("subcommand_byte", want.subcommand, subcommand_byte_o);
        check_field("data_length", want.length, data_length_o);
        check_field("command_index", 8'(want.cmd_idx), 8'(command_index_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("** cobs_crc8_frame_receiver: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    rx_valid_i   = 1'b0;
    rx_byte_i    = '0;
    out_ready_i  = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CfgTableLow;
    cfg_data_i   = '0;
    bytes_sent   = 0;
    fails        = 0;
    hold_request = 0;
    hold_left    = 0;
    src_idle     = 1'b0;
    sink_idle    = 1'b0;
    tbl_lo       = TableLowReset;
    tbl_hi       = TableHighReset;
    cmd_count    = CountReset;
    frame_pos    = 0;
    zero_chain   = '0;
    crc_acc      = '0;
    hdr_cmd      = '0;
    hdr_sub      = '0;
    hdr_len      = '0;
    hit_idx      = '0;
    crc_ok       = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_full_rate();
    test_random_frames();
    test_command_table();
    test_backpressure();
    test_sender_pause();
    test_noise();
    if (frame_pos != 0) send_byte(8'h00);
    wait_drain(DrainCycles);
    if (fails == 0) begin
      $display("** cobs_crc8_frame_receiver: PASSED **");
    end else begin
      $display("** cobs_crc8_frame_receiver: FAILED **");
    end
    $finish;
  end

endmodule

/* cobs_crc8_frame_receiver.f */
rtl/cobs_crc8_pkg.sv
rtl/cobs_crc8_frame_receiver.sv
bench/testbench.sv
